@@ rtl/lacm_pkg.sv @@
package lacm_pkg;

	// Signed Q16.16 limits used for saturation.
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_X_LOW  = 3'd0,
		CFG_X_HIGH = 3'd1,
		CFG_Y_LOW  = 3'd2,
		CFG_Y_HIGH = 3'd3,
		CFG_LOG_X  = 3'd4,
		CFG_LOG_Y  = 3'd5
	} cfg_idx_t;

	// One input word.
	typedef struct packed {
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic               log_to_lin;
	} coord_word_t;

	// One result word.
	typedef struct packed {
		logic signed [31:0] x_result;
		logic signed [31:0] y_result;
	} result_word_t;

	// Range and enable of one axis, handed from the register bank to an axis pipeline.
	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               en;
	} axis_cfg_t;

endpackage

@@ rtl/log_axis_coordinate_map_unit.sv @@
// Linear/logarithmic coordinate mapper for an (x, y) pair in signed Q16.16.
// Input channel: a word on item is taken at every clock edge with start high;
// busy is always low, so a new word may follow in every cycle.
// Result channel: result_strobe is high for one cycle with the mapped pair on
// result; the receiver cannot stall, and none is needed as nothing is held back.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// x low, x high, y low, y high, log x enable, log y enable (0 to 5); other
// indexes are ignored. cfg_ready is always high. Write only while no word is
// in flight.
// The unit takes one word per cycle. Every word passes through the same
// chain of cells: FRAC_BITS log2 squaring cells, one divider cell per
// quotient bit, and 31 square root cells for each exp2 fraction bit.
// Reset clears the in-flight marks and loads the range registers with
// 0 to 1.0 on both axes, both log enables off.
module log_axis_coordinate_map_unit import lacm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  coord_word_t  item,
	output logic         result_strobe,
	output result_word_t result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	axis_cfg_t x_cfg_q;
	axis_cfg_t y_cfg_q;
	logic      x_valid;
	logic      y_valid;
	logic      accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Register bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cfg_q <= '{lo: 32'sd0, hi: 32'sd65536, en: 1'b0};
			y_cfg_q <= '{lo: 32'sd0, hi: 32'sd65536, en: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_LOW:  x_cfg_q.lo <= cfg_data;
				CFG_X_HIGH: x_cfg_q.hi <= cfg_data;
				CFG_Y_LOW:  y_cfg_q.lo <= cfg_data;
				CFG_Y_HIGH: y_cfg_q.hi <= cfg_data;
				CFG_LOG_X:  x_cfg_q.en <= cfg_data[0];
				CFG_LOG_Y:  y_cfg_q.en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// One pipeline per axis; both have the same depth.
	lacm_axis #(.FRAC_BITS(FRAC_BITS)) u_x_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.coord     (item.x_coord),
		.to_lin    (item.log_to_lin),
		.cfg       (x_cfg_q),
		.out_valid (x_valid),
		.out_val   (result.x_result)
	);

	lacm_axis #(.FRAC_BITS(FRAC_BITS)) u_y_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.coord     (item.y_coord),
		.to_lin    (item.log_to_lin),
		.cfg       (y_cfg_q),
		.out_valid (y_valid),
		.out_val   (result.y_result)
	);

	assign result_strobe = x_valid;

	// The two axis pipelines must deliver each word in the same cycle.
	a_axes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid == y_valid)
		else $error("axis pipelines out of step");

	a_cfg_x_low: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == CFG_X_LOW) |=> (x_cfg_q.lo == $past(cfg_data)))
		else $error("x low bound write lost");

	a_cfg_log_y: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == CFG_LOG_Y) |=> (y_cfg_q.en == $past(cfg_data[0])))
		else $error("log y enable write lost");

endmodule

@@ rtl/lacm_log_cell.sv @@
module lacm_log_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [30:0]          x,
	input  logic [FRAC_BITS-1:0] frac,
	output logic [30:0]          x_s1,
	output logic [FRAC_BITS-1:0] frac_s1
);

	logic [61:0] sq;
	logic [31:0] t;

	// Square the Q1.30 mantissa; a square of 2.0 or more yields a fraction bit of one.
	assign sq = x * x;
	assign t  = sq[61:30];

	always_ff @(posedge clk) begin
		if (t[31]) begin
			x_s1    <= t[31:1];
			frac_s1 <= {frac[FRAC_BITS-2:0], 1'b1};
		end else begin
			x_s1    <= t[30:0];
			frac_s1 <= {frac[FRAC_BITS-2:0], 1'b0};
		end
	end

endmodule

@@ rtl/lacm_div_cell.sv @@
module lacm_div_cell #(
	parameter int NW = 55
) (
	input  logic          clk,
	input  logic [32:0]   rem,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] quo,
	input  logic [32:0]   den,
	output logic [32:0]   rem_s1,
	output logic [NW-1:0] num_s1,
	output logic [NW-1:0] quo_s1,
	output logic [32:0]   den_s1
);

	logic [33:0] r2;
	logic [33:0] diff;
	logic        ge;

	// One restoring division step: bring down the next dividend bit and try the divisor.
	assign r2   = {rem, num[NW-1]};
	assign diff = r2 - {1'b0, den};
	assign ge   = (r2 >= {1'b0, den});

	always_ff @(posedge clk) begin
		rem_s1 <= ge ? diff[32:0] : r2[32:0];
		num_s1 <= {num[NW-2:0], 1'b0};
		quo_s1 <= {quo[NW-2:0], ge};
		den_s1 <= den;
	end

endmodule

@@ rtl/lacm_sqrt_cell.sv @@
module lacm_sqrt_cell (
	input  logic        clk,
	input  logic [32:0] rem,
	input  logic [30:0] root,
	input  logic [61:0] rad,
	output logic [32:0] rem_s1,
	output logic [30:0] root_s1,
	output logic [61:0] rad_s1
);

	logic [34:0] r2;
	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;

	// One digit-by-digit square root step: two radicand bits in, one root bit out.
	assign r2    = {rem, rad[61:60]};
	assign trial = {2'b00, root, 2'b01};
	assign diff  = r2 - trial;
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk) begin
		rem_s1  <= ge ? diff[32:0] : r2[32:0];
		root_s1 <= {root[29:0], ge};
		rad_s1  <= {rad[59:0], 2'b00};
	end

endmodule

@@ rtl/lacm_axis.sv @@
module lacm_axis import lacm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] coord,
	input  logic               to_lin,
	input  axis_cfg_t          cfg,
	output logic               out_valid,
	output logic [31:0]        out_val
);

	localparam int F    = FRAC_BITS;
	localparam int LW   = F + 5;
	localparam int SW   = LW + 1;
	localparam int NW   = 33 + SW;
	localparam int NSQ  = 31;
	localparam int NEXP = F * NSQ;
	localparam int PW   = F + 33;
	localparam int TW   = PW + 31;
	localparam int LAT  = 1 + F + 3 + NW + 1 + NEXP + 2;
	localparam int IV   = 0;
	localparam int ILO  = 1;
	localparam int IHI  = 2;

	typedef struct packed {
		logic        done;
		logic [31:0] val;
		logic        to_lin;
		logic [31:0] lo;
	} ctl_t;

	function automatic logic [4:0] top_bit(input logic [30:0] u);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 31; i++) begin
			if (u[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

	logic [LAT-1:0] vld_q;

	// Valid marks travel alongside the data, one bit per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[LAT-1];

	// Stage one: early outcomes and mantissa normalisation of the coordinate and both bounds.
	ctl_t        ctl_d;
	logic [30:0] u_d [3];
	logic [4:0]  n_d [3];

	always_comb begin
		ctl_d.to_lin = to_lin;
		ctl_d.lo     = cfg.lo;
		if (!cfg.en) begin
			ctl_d.done = 1'b1;
			ctl_d.val  = coord;
		end else if ((coord < cfg.lo) || (cfg.lo <= 0) || (cfg.hi <= 0)) begin
			ctl_d.done = 1'b1;
			ctl_d.val  = cfg.lo;
		end else begin
			ctl_d.done = 1'b0;
			ctl_d.val  = '0;
		end
	end

	assign u_d[IV]  = coord[30:0];
	assign u_d[ILO] = cfg.lo[30:0];
	assign u_d[IHI] = cfg.hi[30:0];

	ctl_t               ctl_lg  [F+1];
	logic signed [31:0] v_lg    [F+1];
	logic signed [31:0] hi_lg   [F+1];
	logic [4:0]         n_lg    [F+1][3];
	logic [30:0]        x_lg    [F+1][3];
	logic [F-1:0]       frac_lg [F+1][3];

	for (genvar j = 0; j < 3; j++) begin : g_norm
		assign n_d[j] = top_bit(u_d[j]);

		always_ff @(posedge clk) begin
			n_lg[0][j]    <= n_d[j];
			x_lg[0][j]    <= u_d[j] << (5'd30 - n_d[j]);
			frac_lg[0][j] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		ctl_lg[0] <= ctl_d;
		v_lg[0]   <= coord;
		hi_lg[0]  <= cfg.hi;
	end

	// Log2 fraction chain: one squaring cell per fraction bit for each of the three values.
	for (genvar k = 0; k < F; k++) begin : g_log
		for (genvar j = 0; j < 3; j++) begin : g_val
			lacm_log_cell #(.FRAC_BITS(F)) u_cell (
				.clk     (clk),
				.x       (x_lg[k][j]),
				.frac    (frac_lg[k][j]),
				.x_s1    (x_lg[k+1][j]),
				.frac_s1 (frac_lg[k+1][j])
			);

			always_ff @(posedge clk) begin
				n_lg[k+1][j] <= n_lg[k][j];
			end
		end

		always_ff @(posedge clk) begin
			ctl_lg[k+1] <= ctl_lg[k];
			v_lg[k+1]   <= v_lg[k];
			hi_lg[k+1]  <= hi_lg[k];
		end
	end

	// Stage two: log differences, and the operands of the product and the divisor.
	logic [LW-1:0]      lv;
	logic [LW-1:0]      llo;
	logic [LW-1:0]      lhi;
	logic signed [SW-1:0] d_d;
	logic signed [SW-1:0] r_d;
	logic signed [32:0] v33;
	logic signed [32:0] lo33;
	logic signed [32:0] hi33;
	ctl_t               ctl_m;
	logic signed [32:0] op1_d;
	logic signed [SW-1:0] op2_d;
	logic signed [32:0] den_d;

	assign lv   = {n_lg[F][IV], frac_lg[F][IV]};
	assign llo  = {n_lg[F][ILO], frac_lg[F][ILO]};
	assign lhi  = {n_lg[F][IHI], frac_lg[F][IHI]};
	assign d_d  = $signed({1'b0, lv}) - $signed({1'b0, llo});
	assign r_d  = $signed({1'b0, lhi}) - $signed({1'b0, llo});
	assign v33  = {v_lg[F][31], v_lg[F]};
	assign lo33 = {ctl_lg[F].lo[31], ctl_lg[F].lo};
	assign hi33 = {hi_lg[F][31], hi_lg[F]};

	always_comb begin
		ctl_m = ctl_lg[F];
		if (ctl_lg[F].to_lin) begin
			op1_d = hi33 - lo33;
			op2_d = d_d;
			den_d = {{(33-SW){r_d[SW-1]}}, r_d};
		end else begin
			op1_d = v33 - lo33;
			op2_d = r_d;
			den_d = hi33 - lo33;
		end
		if (!ctl_lg[F].done && (den_d == '0)) begin
			ctl_m.done = 1'b1;
			ctl_m.val  = ctl_lg[F].lo;
		end
	end

	ctl_t                 ctl_s2;
	logic signed [32:0]   op1_s2;
	logic signed [SW-1:0] op2_s2;
	logic signed [32:0]   den_s2;

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_m;
		op1_s2 <= op1_d;
		op2_s2 <= op2_d;
		den_s2 <= den_d;
	end

	// Stage three: the signed product that forms the dividend.
	logic signed [NW-1:0] prod_d;
	ctl_t                 ctl_s3;
	logic signed [NW-1:0] prod_s3;
	logic signed [32:0]   den_s3;

	assign prod_d = op1_s2 * op2_s2;

	always_ff @(posedge clk) begin
		ctl_s3  <= ctl_s2;
		prod_s3 <= prod_d;
		den_s3  <= den_s2;
	end

	// Stage four: magnitudes and the quotient sign.
	ctl_t          ctl_dv  [NW+1];
	logic          neg_dv  [NW+1];
	logic [32:0]   rem_dv  [NW+1];
	logic [NW-1:0] num_dv  [NW+1];
	logic [NW-1:0] quo_dv  [NW+1];
	logic [32:0]   den_dv  [NW+1];

	always_ff @(posedge clk) begin
		ctl_dv[0] <= ctl_s3;
		neg_dv[0] <= prod_s3[NW-1] ^ den_s3[32];
		rem_dv[0] <= '0;
		num_dv[0] <= prod_s3[NW-1] ? NW'(-prod_s3) : NW'(prod_s3);
		quo_dv[0] <= '0;
		den_dv[0] <= den_s3[32] ? 33'(-den_s3) : 33'(den_s3);
	end

	// Divider chain: one quotient bit per cell, truncating toward zero.
	for (genvar k = 0; k < NW; k++) begin : g_div
		lacm_div_cell #(.NW(NW)) u_cell (
			.clk    (clk),
			.rem    (rem_dv[k]),
			.num    (num_dv[k]),
			.quo    (quo_dv[k]),
			.den    (den_dv[k]),
			.rem_s1 (rem_dv[k+1]),
			.num_s1 (num_dv[k+1]),
			.quo_s1 (quo_dv[k+1]),
			.den_s1 (den_dv[k+1])
		);

		always_ff @(posedge clk) begin
			ctl_dv[k+1] <= ctl_dv[k];
			neg_dv[k+1] <= neg_dv[k];
		end
	end

	// Stage five: linear result with saturation, or exponent split (saturating on overflow) for the log result.
	logic signed [NW:0]   qs;
	logic signed [NW+1:0] sum;
	logic [NW-1:0]        e;
	ctl_t                 ctl_p;

	assign qs  = neg_dv[NW] ? -$signed({1'b0, quo_dv[NW]}) : $signed({1'b0, quo_dv[NW]});
	assign sum = $signed({{(NW-30){ctl_dv[NW].lo[31]}}, ctl_dv[NW].lo}) + $signed({qs[NW], qs});
	assign e   = qs[NW] ? '0 : qs[NW-1:0];

	always_comb begin
		ctl_p = ctl_dv[NW];
		if (!ctl_dv[NW].done) begin
			if (ctl_dv[NW].to_lin) begin
				ctl_p.done = 1'b1;
				if ((sum[NW+1:31] == '0) || (sum[NW+1:31] == '1)) begin
					ctl_p.val = sum[31:0];
				end else begin
					ctl_p.val = sum[NW+1] ? Q_MIN : Q_MAX;
				end
			end else if (e[NW-1:F+5] != '0) begin
				ctl_p.done = 1'b1;
				ctl_p.val  = Q_MAX;
			end
		end
	end

	ctl_t         ctl_sq  [NEXP+1];
	logic [4:0]   ip_sq   [NEXP+1];
	logic [F-1:0] f_sq    [NEXP+1];
	logic [32:0]  rem_sq  [NEXP+1];
	logic [30:0]  root_sq [NEXP+1];
	logic [61:0]  rad_sq  [NEXP+1];

	always_ff @(posedge clk) begin
		ctl_sq[0]  <= ctl_p;
		ip_sq[0]   <= e[F+4:F];
		f_sq[0]    <= e[F-1:0];
		rem_sq[0]  <= '0;
		root_sq[0] <= 31'h4000_0000;
		rad_sq[0]  <= '0;
	end

	// Exp2 chain: per fraction bit, an optional doubling then a square root of NSQ cells.
	for (genvar g = 0; g < NEXP; g++) begin : g_exp
		localparam int K = g / NSQ;
		localparam int C = g % NSQ;
		logic [32:0] rem_in;
		logic [30:0] root_in;
		logic [61:0] rad_in;

		if (C == 0) begin : g_head
			logic [31:0] xm;
			assign xm      = f_sq[g][K] ? {root_sq[g], 1'b0} : {1'b0, root_sq[g]};
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {xm, 30'd0};
		end else begin : g_body
			assign rem_in  = rem_sq[g];
			assign root_in = root_sq[g];
			assign rad_in  = rad_sq[g];
		end

		lacm_sqrt_cell u_cell (
			.clk     (clk),
			.rem     (rem_in),
			.root    (root_in),
			.rad     (rad_in),
			.rem_s1  (rem_sq[g+1]),
			.root_s1 (root_sq[g+1]),
			.rad_s1  (rad_sq[g+1])
		);

		always_ff @(posedge clk) begin
			ctl_sq[g+1] <= ctl_sq[g];
			ip_sq[g+1]  <= ip_sq[g];
			f_sq[g+1]   <= f_sq[g];
		end
	end

	// Stage six: scale the minimum by the exp2 mantissa.
	logic [F:0]    mq;
	ctl_t          ctl_s6;
	logic [4:0]    ip_s6;
	logic [PW-1:0] p_s6;

	assign mq = root_sq[NEXP][30:30-F];

	always_ff @(posedge clk) begin
		ctl_s6 <= ctl_sq[NEXP];
		ip_s6  <= ip_sq[NEXP];
		p_s6   <= PW'(ctl_sq[NEXP].lo) * PW'(mq);
	end

	// Stage seven: apply the integer exponent and saturate.
	logic [TW-1:0] w;
	ctl_t          ctl_f;
	ctl_t          ctl_s7;

	assign w = TW'(p_s6) << ip_s6;

	always_comb begin
		ctl_f = ctl_s6;
		if (!ctl_s6.done) begin
			ctl_f.done = 1'b1;
			ctl_f.val  = (w[TW-1:F+31] == '0) ? w[F+30:F] : Q_MAX;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s7 <= ctl_f;
	end

	assign out_val = ctl_s7.val;

endmodule
